FILE: sv/rbs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbs_pkg
// Shared types and constants for the rectangle blit to swapped RGB565 unit.
// ----------------------------------------------------------------------------
package rbs_pkg;

  // Palette geometry.
  localparam int unsigned PAL_ENTRIES = 256;
  localparam int unsigned PAL_IDX_W   = $clog2(PAL_ENTRIES);

  // Field widths fixed by the interface.
  localparam int unsigned ADDR_W  = 24;
  localparam int unsigned LW_W    = 13;
  localparam int unsigned COLOR_W = 24;
  localparam int unsigned WORD_W  = 16;

  // Largest row stride accepted; larger writes saturate to it.
  localparam logic [LW_W-1:0] MAX_LINE_WIDTH = 13'd4096;
  localparam logic [LW_W-1:0] LINE_WIDTH_RST = 13'd640;

  // Input transaction kinds.
  typedef enum logic [1:0] {
    ACT_PAL_WRITE = 2'd0,
    ACT_BEGIN     = 2'd1,
    ACT_REFRESH   = 2'd2,
    ACT_FILL      = 2'd3
  } action_e;

  // Source pixel formats.
  typedef enum logic [1:0] {
    FMT_PALETTE = 2'd0,
    FMT_RGB565  = 2'd1,
    FMT_RGB888  = 2'd2,
    FMT_SPARE   = 2'd3
  } format_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_LINE_WIDTH    = 2'd0,
    REG_SOURCE_FORMAT = 2'd1,
    REG_NONE_2        = 2'd2,
    REG_NONE_3        = 2'd3
  } reg_idx_e;

  // Control passed to the pixel converter.
  typedef struct packed {
    format_e fmt;
    logic    fill;
    logic    pal_oob;
  } conv_ctrl_t;

endpackage
`default_nettype wire

FILE: sv/rect_blit_to_rgb565_swapped_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rect_blit_to_rgb565_swapped_unit
// Rectangle blit that converts source pixels into byte-swapped RGB565 words
// with their destination word addresses.
// ----------------------------------------------------------------------------
// The unit accepts one input transaction per clock while the input is not
// stalled, and returns one result for every pixel that falls inside the
// current rectangle. The accepting edge steps the address counters and
// captures the pixel, its address and a registered palette read into a first
// register. The colour is then converted into the output register once that
// register has room. The input stalls only while both registers hold a result
// and the output is not taken. Palette writes and begin transactions give no
// result, nor do pixels outside a rectangle. The palette has no reset and
// needs no clearing; configuration is to be written by the user only while
// the unit is idle, and the unit itself does not enforce this.
// ----------------------------------------------------------------------------
module rect_blit_to_rgb565_swapped_unit
  import rbs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration write channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [LW_W-1:0]    cfg_data_i,
  // Input channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         action_i,
  input  logic [11:0]        rect_x_i,
  input  logic [11:0]        rect_y_i,
  input  logic [12:0]        rect_w_i,
  input  logic [12:0]        rect_h_i,
  input  logic [23:0]        pixel_value_i,
  input  logic [7:0]         palette_index_i,
  input  logic [23:0]        palette_color_i,
  // Output channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [23:0]        dest_address_o,
  output logic [15:0]        dest_data_o,
  output logic               last_pixel_o
);

  // Configuration registers.
  logic [LW_W-1:0] line_width_q;
  format_e         source_format_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q    <= LINE_WIDTH_RST;
      source_format_q <= FMT_RGB565;
    end else if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_LINE_WIDTH: begin
          line_width_q <= (cfg_data_i > MAX_LINE_WIDTH) ? MAX_LINE_WIDTH : cfg_data_i;
        end
        REG_SOURCE_FORMAT: begin
          source_format_q <= format_e'(cfg_data_i[1:0]);
        end
        default: ;
      endcase
    end
  end

  // Pipeline flow control: each stage moves when the one after it has room.
  logic s1_valid_q;
  logic out_valid_q;
  logic out_load;
  logic s1_adv;
  logic in_fire;

  assign out_load   = !out_valid_q || out_ready_i;
  assign s1_adv     = !s1_valid_q || out_load;
  assign in_ready_o = s1_adv;
  assign in_fire    = in_valid_i && s1_adv;

  // Rectangle walk state.
  logic [12:0]       column_count_q, column_count_d;
  logic [12:0]       rows_left_q,    rows_left_d;
  logic [12:0]       rect_width_q,   rect_width_d;
  logic [ADDR_W-1:0] cur_addr_q,     cur_addr_d;
  logic [ADDR_W-1:0] row_start_q,    row_start_d;

  action_e           action;
  logic              pix_emit;
  logic [12:0]       col_inc;
  logic              row_end;
  logic [24:0]       begin_prod;
  logic [ADDR_W-1:0] begin_addr;
  logic [ADDR_W-1:0] next_row;

  assign action     = action_e'(action_i);
  assign pix_emit   = (action == ACT_REFRESH || action == ACT_FILL) && (rows_left_q != '0);
  assign col_inc    = column_count_q + 13'd1;
  assign row_end    = (col_inc == rect_width_q);
  assign begin_prod = 25'(rect_y_i) * 25'(line_width_q);
  assign begin_addr = begin_prod[ADDR_W-1:0] + ADDR_W'(rect_x_i);
  assign next_row   = row_start_q + ADDR_W'(line_width_q);

  // Next state of the walk for the transaction at the input.
  always_comb begin
    column_count_d = column_count_q;
    rows_left_d    = rows_left_q;
    rect_width_d   = rect_width_q;
    cur_addr_d     = cur_addr_q;
    row_start_d    = row_start_q;
    case (action)
      ACT_BEGIN: begin
        rect_width_d   = rect_w_i;
        rows_left_d    = (rect_w_i == '0) ? '0 : rect_h_i;
        column_count_d = '0;
        row_start_d    = begin_addr;
        cur_addr_d     = begin_addr;
      end
      ACT_REFRESH, ACT_FILL: begin
        if (pix_emit) begin
          if (row_end) begin
            column_count_d = '0;
            rows_left_d    = rows_left_q - 13'd1;
            row_start_d    = next_row;
            cur_addr_d     = next_row;
          end else begin
            column_count_d = col_inc;
            cur_addr_d     = cur_addr_q + 24'd1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_count_q <= '0;
      rows_left_q    <= '0;
      rect_width_q   <= '0;
      cur_addr_q     <= '0;
      row_start_q    <= '0;
    end else if (in_fire) begin
      column_count_q <= column_count_d;
      rows_left_q    <= rows_left_d;
      rect_width_q   <= rect_width_d;
      cur_addr_q     <= cur_addr_d;
      row_start_q    <= row_start_d;
    end
  end

  // Palette memory: written by palette transactions, read for every pixel.
  logic [COLOR_W-1:0] pal_mem [PAL_ENTRIES];
  logic [COLOR_W-1:0] pal_rd_q;
  logic               pal_wr_ok;
  logic               pal_rd_ok;

  assign pal_wr_ok = ({1'b0, palette_index_i} < 9'(PAL_ENTRIES));
  assign pal_rd_ok = ({1'b0, pixel_value_i[7:0]} < 9'(PAL_ENTRIES));

  always_ff @(posedge clk_i) begin
    if (in_fire && action == ACT_PAL_WRITE && pal_wr_ok) begin
      pal_mem[palette_index_i[PAL_IDX_W-1:0]] <= palette_color_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      pal_rd_q <= pal_mem[pixel_value_i[PAL_IDX_W-1:0]];
    end
  end

  // First stage register: the pixel with its address and end flag.
  logic [ADDR_W-1:0]  s1_addr_q;
  logic               s1_last_q;
  logic [COLOR_W-1:0] s1_pixel_q;
  logic               s1_fill_q;
  logic               s1_oob_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_q <= in_fire && pix_emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_addr_q  <= cur_addr_q;
      s1_last_q  <= (rows_left_q == 13'd1) && row_end;
      s1_pixel_q <= pixel_value_i;
      s1_fill_q  <= (action == ACT_FILL);
      s1_oob_q   <= !pal_rd_ok;
    end
  end

  // Colour conversion.
  conv_ctrl_t         conv_ctrl;
  logic [WORD_W-1:0]  conv_word;

  assign conv_ctrl.fmt     = source_format_q;
  assign conv_ctrl.fill    = s1_fill_q;
  assign conv_ctrl.pal_oob = s1_oob_q;

  rbs_pix_conv u_conv (
    .ctrl_i      (conv_ctrl),
    .pixel_i     (s1_pixel_q),
    .pal_color_i (pal_rd_q),
    .word_o      (conv_word)
  );

  // Output register.
  logic [ADDR_W-1:0] out_addr_q;
  logic [WORD_W-1:0] out_data_q;
  logic              out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && s1_valid_q) begin
      out_addr_q <= s1_addr_q;
      out_data_q <= conv_word;
      out_last_q <= s1_last_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign dest_address_o = out_addr_q;
  assign dest_data_o    = out_data_q;
  assign last_pixel_o   = out_last_q;

endmodule
`default_nettype wire

FILE: sv/rbs_pix_conv.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbs_pix_conv
// Turns one source pixel into an RGB565 word, byte-swapped except for a
// 16-bit fill.
// ----------------------------------------------------------------------------
module rbs_pix_conv
  import rbs_pkg::*;
(
  input  conv_ctrl_t           ctrl_i,
  input  logic [COLOR_W-1:0]   pixel_i,
  input  logic [COLOR_W-1:0]   pal_color_i,
  output logic [WORD_W-1:0]    word_o
);

  // Keep the top 5, 6 and 5 bits of red, green and blue.
  function automatic logic [WORD_W-1:0] to565(input logic [COLOR_W-1:0] c);
    to565 = {c[23:19], c[15:10], c[7:3]};
  endfunction

  function automatic logic [WORD_W-1:0] swap16(input logic [WORD_W-1:0] v);
    swap16 = {v[7:0], v[15:8]};
  endfunction

  logic [COLOR_W-1:0] pal_eff;

  // An index beyond the palette reads as black.
  assign pal_eff = ctrl_i.pal_oob ? '0 : pal_color_i;

  // Format selection; the spare code behaves as RGB888.
  always_comb begin
    case (ctrl_i.fmt)
      FMT_PALETTE: word_o = swap16(to565(pal_eff));
      FMT_RGB565:  word_o = ctrl_i.fill ? pixel_i[WORD_W-1:0]
                                        : swap16(pixel_i[WORD_W-1:0]);
      default:     word_o = swap16(to565(pixel_i));
    endcase
  end

endmodule
`default_nettype wire
